@@ design/tbcpt_pkg.sv @@
// Package for the time-based cover position tracker: codes, constants, field
// layout and the helper that starts a direction of travel.
// No dependencies; imported by the core and by its checker.
package tbcpt_pkg;

    localparam int unsigned PosW  = 32;
    localparam int unsigned StepW = 32;

    localparam logic [PosW-1:0]  PosOpen   = 32'h8000_0000;
    localparam logic [PosW-1:0]  PosClosed = 32'h0000_0000;
    localparam logic [PosW-1:0]  PosHalf   = 32'h4000_0000;
    localparam logic [StepW-1:0] StepReset = 32'd35791;

    // Stream widths; the data widths are padded to whole bytes
    localparam int unsigned InDataW  = 32;
    localparam int unsigned InUserW  = 2;
    localparam int unsigned OutDataW = 40;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_STOP   = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_MOVE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_IDLE    = 2'd0,
        OP_OPENING = 2'd1,
        OP_CLOSING = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        PULSE_NONE  = 2'd0,
        PULSE_STOP  = 2'd1,
        PULSE_OPEN  = 2'd2,
        PULSE_CLOSE = 2'd3
    } t_pulse;

    typedef enum logic [1:0] {
        REG_OPEN_STEP     = 2'd0,
        REG_CLOSE_STEP    = 2'd1,
        REG_HAS_ENDSTOP   = 2'd2,
        REG_MANUAL_SWITCH = 2'd3
    } t_reg;

    typedef struct packed {
        t_pulse pulse;
        t_op    op;
        logic   last_closing;
    } t_dir_res;

    // Starting the direction already under way changes nothing; asking for
    // idle always gives a stop pulse.
    function automatic t_dir_res begin_dir(t_op dir, t_op op, logic last_closing);
        t_dir_res r;
        r.pulse        = PULSE_NONE;
        r.op           = op;
        r.last_closing = last_closing;
        if (!(dir == op && dir != OP_IDLE)) begin
            r.op = dir;
            case (dir)
                OP_OPENING: begin
                    r.last_closing = 1'b0;
                    r.pulse        = PULSE_OPEN;
                end
                OP_CLOSING: begin
                    r.last_closing = 1'b1;
                    r.pulse        = PULSE_CLOSE;
                end
                default: r.pulse = PULSE_STOP;
            endcase
        end
        return r;
    endfunction

    function automatic logic is_end(logic [PosW-1:0] p);
        return (p == PosOpen) || (p == PosClosed);
    endfunction

endpackage

@@ design/time_based_cover_position_tracker_core.sv @@
// Channel  | Direction | Payload (lowest bit first)                  | Accept
// ---------+-----------+---------------------------------------------+-------------------
// s_axis   | in        | tuser: cmd; tdata: goal_position            | tvalid && tready
// m_axis   | out       | tdata: motor_command, position_now, motion, | tvalid && tready
//          |           |        arrived, zero padding                |
// cfg      | in        | index, data (register write)                | valid && ready
//
// Top level of the time-based cover position tracker. Depends on tbcpt_pkg.
// One item is taken per clock cycle while s_axis_tready is high: the add,
// clamp and compare on the position register all complete in the cycle the
// item is accepted, and the result is written to the output register (or to
// the skid register if the output is stalled).
// Reset is synchronous on i_rst_n low: position returns to half open, target
// to closed, motion to idle, and both steps to their default of 35791.
// s_axis_tready falls only while the skid register holds an item, so input
// and output stalls are decoupled by one item of buffering.
module time_based_cover_position_tracker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tuser: cmd[1:0]
    input  logic [tbcpt_pkg::InUserW-1:0]  s_axis_tuser,
    // tdata: goal_position[31:0]
    input  logic [tbcpt_pkg::InDataW-1:0]  s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: motor_command[1:0], position_now[33:2], motion[35:34],
    //        arrived[36], zero[39:37]
    output logic [tbcpt_pkg::OutDataW-1:0] m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import tbcpt_pkg::*;

    // Configuration registers
    logic [StepW-1:0] r_open_step;
    logic [StepW-1:0] r_close_step;
    logic             r_has_endstop;
    logic             r_manual_switch;

    // Tracker state
    logic [PosW-1:0] r_pos;
    logic [PosW-1:0] r_target;
    t_op             r_op;
    logic            r_last_closing;

    logic [PosW-1:0] n_pos;
    logic [PosW-1:0] n_target;
    t_op             n_op;
    logic            n_last_closing;

    // Output register and skid register
    logic [OutDataW-1:0] r_out;
    logic                r_out_valid;
    logic [OutDataW-1:0] r_skid;
    logic                r_skid_valid;

    logic            in_fire;
    logic            out_pop;
    t_cmd            cmd;
    logic [PosW-1:0] goal;
    t_pulse          pulse;
    logic            arrived;
    logic [PosW:0]   open_sum;
    logic            hit;
    t_op             dir;
    t_dir_res        dres;
    logic [OutDataW-1:0] result;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_pop       = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign cmd  = t_cmd'(s_axis_tuser);
    // A goal beyond fully open is held at fully open
    assign goal = (s_axis_tdata > PosOpen) ? PosOpen : s_axis_tdata;

    assign open_sum = {1'b0, r_pos} + {1'b0, r_open_step};

    always_comb begin
        n_pos          = r_pos;
        n_target       = r_target;
        n_op           = r_op;
        n_last_closing = r_last_closing;
        pulse          = PULSE_NONE;
        arrived        = 1'b0;
        hit            = 1'b0;
        dir            = OP_IDLE;
        dres           = begin_dir(OP_IDLE, r_op, r_last_closing);

        case (cmd)
            CMD_TICK: begin
                if (r_op == OP_OPENING || r_op == OP_CLOSING) begin
                    if (r_op == OP_OPENING) begin
                        n_pos = (open_sum > {1'b0, PosOpen}) ? PosOpen
                                                             : open_sum[PosW-1:0];
                        hit   = n_pos >= r_target;
                    end else begin
                        n_pos = (r_close_step >= r_pos) ? PosClosed
                                                        : r_pos - r_close_step;
                        hit   = n_pos <= r_target;
                    end
                    if (hit) begin
                        arrived = 1'b1;
                        n_op    = OP_IDLE;
                        // An end-stop cover halts itself at either end
                        if (!(r_has_endstop && is_end(r_target))) begin
                            pulse = dres.pulse;
                        end
                    end
                end
            end
            CMD_STOP: begin
                pulse = dres.pulse;
                n_op  = dres.op;
            end
            CMD_TOGGLE: begin
                if (r_op != OP_IDLE) begin
                    dir = OP_IDLE;
                end else if (r_pos == PosClosed || r_last_closing) begin
                    dir      = OP_OPENING;
                    n_target = PosOpen;
                end else begin
                    dir      = OP_CLOSING;
                    n_target = PosClosed;
                end
                dres           = begin_dir(dir, r_op, r_last_closing);
                pulse          = dres.pulse;
                n_op           = dres.op;
                n_last_closing = dres.last_closing;
            end
            default: begin
                if (goal == r_pos) begin
                    // Already there: only the manual-switch flip or the
                    // end-stop resend start a move, and only at an end.
                    dir = (goal == PosClosed) ? OP_CLOSING : OP_OPENING;
                    if ((r_manual_switch || r_has_endstop) && is_end(goal)) begin
                        if (r_manual_switch) begin
                            n_pos = (goal == PosClosed) ? PosOpen : PosClosed;
                        end
                        n_target       = goal;
                        dres           = begin_dir(dir, r_op, r_last_closing);
                        pulse          = dres.pulse;
                        n_op           = dres.op;
                        n_last_closing = dres.last_closing;
                    end
                end else begin
                    dir = (goal < r_pos) ? OP_CLOSING : OP_OPENING;
                    // With a manual switch the cover is assumed to start at
                    // the opposite end from the one requested.
                    if (r_manual_switch && is_end(goal)) begin
                        n_pos = (goal == PosClosed) ? PosOpen : PosClosed;
                    end
                    n_target       = goal;
                    dres           = begin_dir(dir, r_op, r_last_closing);
                    pulse          = dres.pulse;
                    n_op           = dres.op;
                    n_last_closing = dres.last_closing;
                end
            end
        endcase
    end

    assign result = {3'b000, arrived, n_op, n_pos, pulse};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_step     <= StepReset;
            r_close_step    <= StepReset;
            r_has_endstop   <= 1'b0;
            r_manual_switch <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg'(i_cfg_index))
                REG_OPEN_STEP:     r_open_step     <= i_cfg_data;
                REG_CLOSE_STEP:    r_close_step    <= i_cfg_data;
                REG_HAS_ENDSTOP:   r_has_endstop   <= i_cfg_data[0];
                REG_MANUAL_SWITCH: r_manual_switch <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= PosHalf;
            r_target       <= PosClosed;
            r_op           <= OP_IDLE;
            r_last_closing <= 1'b0;
        end else if (in_fire) begin
            r_pos          <= n_pos;
            r_target       <= n_target;
            r_op           <= n_op;
            r_last_closing <= n_last_closing;
        end
    end

    // The skid register fills only when a new item arrives while the output
    // register is held; it drains into the output register when that empties.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_pop) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end
    end

endmodule

@@ design/tbcpt_checker.sv @@
// Port-level checker for the time-based cover position tracker core, and the
// bind that attaches it. Depends on tbcpt_pkg.
module tbcpt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic [tbcpt_pkg::OutDataW-1:0] m_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready
);
    import tbcpt_pkg::*;

    logic [1:0]      out_pulse;
    logic [PosW-1:0] out_pos;
    logic [1:0]      out_motion;
    logic            out_arrived;

    assign out_pulse   = m_axis_tdata[1:0];
    assign out_pos     = m_axis_tdata[33:2];
    assign out_motion  = m_axis_tdata[35:34];
    assign out_arrived = m_axis_tdata[36];

    // A stalled result holds its place and value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The estimate never leaves the closed..open range.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> out_pos <= PosOpen)
        else $error("position out of range");

    // Arrival always leaves the cover idle.
    a_arrive_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_arrived |-> out_motion == OP_IDLE)
        else $error("arrived while still moving");

    // A motor pulse always agrees with the motion that follows it.
    a_pulse_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_pulse != PULSE_NONE |->
            (out_pulse == PULSE_STOP  && out_motion == OP_IDLE)    ||
            (out_pulse == PULSE_OPEN  && out_motion == OP_OPENING) ||
            (out_pulse == PULSE_CLOSE && out_motion == OP_CLOSING))
        else $error("motor pulse disagrees with motion");

    // With nothing buffered, the block keeps taking items.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input held off with an empty output");

endmodule

bind time_based_cover_position_tracker_core tbcpt_checker u_tbcpt_checker (.*);
